/* sv/ipv4cv_pkg.sv */
// Shared types, codes and helpers for the IPv4/L4 receive checksum checker.
package ipv4cv_pkg;

    // Bytes of link header before the IP header starts (fixed at 14 here).
    localparam int LinkHdrBytes = 14;

    localparam logic [16:0] PosMax    = 17'h1FFFF;
    localparam logic [7:0]  ProtoTcp  = 8'd6;
    localparam logic [7:0]  ProtoUdp  = 8'd17;
    localparam logic [3:0]  MinHdrWds = 4'd5;
    localparam logic [15:0] TcpMinLen = 16'd20;
    localparam logic [15:0] UdpMinLen = 16'd8;
    localparam logic [15:0] SumOk     = 16'hFFFF;

    // ip_status / transport_status codes
    localparam logic [1:0] StValid   = 2'd0;
    localparam logic [1:0] StInvalid = 2'd1;
    localparam logic [1:0] StUnknown = 2'd2;
    localparam logic [1:0] StNotChk  = 2'd3;

    // transport_kind codes
    localparam logic [1:0] KindOther = 2'd0;
    localparam logic [1:0] KindTcp   = 2'd1;
    localparam logic [1:0] KindUdp   = 2'd2;

    typedef struct packed {
        logic [1:0] ip_status;
        logic [1:0] transport_kind;
        logic [1:0] transport_status;
        logic       short_frame;
    } t_result;

    // 16-bit ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

/* sv/ipv4cv_ifs.sv */
// Valid/ready channel interfaces for frame bytes and per-frame results.
interface ipv4cv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface ipv4cv_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] ip_status;
    logic [1:0] transport_kind;
    logic [1:0] transport_status;
    logic       short_frame;

    modport source (output valid, output ip_status, output transport_kind,
                    output transport_status, output short_frame, input ready);
    modport sink   (input valid, input ip_status, input transport_kind,
                    input transport_status, input short_frame, output ready);
endinterface

/* sv/ipv4cv_parse.sv */
// Per-frame parse state, running checksums and end-of-frame verdict.
module ipv4cv_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    output ipv4cv_pkg::t_result  o_result
);
    import ipv4cv_pkg::*;

    logic [16:0] r_pos,  n_pos;
    logic [3:0]  r_hw,   n_hw;
    logic [15:0] r_dlen, n_dlen;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_hsum, n_hsum;
    logic [15:0] r_tsum, n_tsum;
    logic [7:0]  r_pend, n_pend;
    logic        r_udpz, n_udpz;

    logic [16:0] rel;
    logic [16:0] tofs;
    logic [5:0]  hlen;
    logic [16:0] ipb;
    logic [15:0] tlen;
    logic [15:0] minlen;
    logic [15:0] fsum;
    logic        in_ip;

    always_comb begin
        n_pos   = (r_pos != PosMax) ? r_pos + 17'd1 : r_pos;
        n_hw    = r_hw;
        n_dlen  = r_dlen;
        n_proto = r_proto;
        n_hsum  = r_hsum;
        n_tsum  = r_tsum;
        n_pend  = r_pend;
        n_udpz  = r_udpz;
        in_ip   = r_pos >= 17'(LinkHdrBytes);
        rel     = r_pos - 17'(LinkHdrBytes);
        hlen    = {r_hw, 2'b00};
        tofs    = '0;
        if (in_ip) begin
            if (rel == 17'd0) n_hw = i_byte[3:0];
            if (rel == 17'd2) n_dlen[15:8] = i_byte;
            if (rel == 17'd3) n_dlen[7:0] = i_byte;
            if (rel == 17'd9) n_proto = i_byte;
            hlen = {n_hw, 2'b00};
            tofs = rel - {11'b0, hlen};
            if (rel < {11'b0, hlen}) begin
                if (!rel[0]) begin
                    n_pend = i_byte;
                end else begin
                    n_hsum = oc_add(r_hsum, {r_pend, i_byte});
                    // source and destination addresses seed the pseudo-header
                    if (rel >= 17'd12 && rel <= 17'd19)
                        n_tsum = oc_add(r_tsum, {r_pend, i_byte});
                end
            end else if (n_hw >= MinHdrWds && rel < {1'b0, n_dlen}) begin
                if (n_proto == ProtoUdp && (tofs == 17'd6 || tofs == 17'd7)
                    && i_byte != 8'd0)
                    n_udpz = 1'b0;
                if (!rel[0]) begin
                    // odd-length tail: pad with a zero low byte
                    if (rel + 17'd1 == {1'b0, n_dlen})
                        n_tsum = oc_add(r_tsum, {i_byte, 8'h00});
                    else
                        n_pend = i_byte;
                end else begin
                    n_tsum = oc_add(r_tsum, {r_pend, i_byte});
                end
            end
        end
    end

    // verdict from the state as it stands after this byte
    always_comb begin
        ipb    = r_pos - 17'(LinkHdrBytes - 1);
        tlen   = n_dlen - {10'b0, hlen};
        fsum   = oc_add(oc_add(n_tsum, {8'h00, n_proto}), tlen);
        minlen = (n_proto == ProtoTcp) ? TcpMinLen : UdpMinLen;
        o_result.short_frame      = 1'b0;
        o_result.ip_status        = StUnknown;
        o_result.transport_kind   = KindOther;
        o_result.transport_status = StNotChk;
        if (r_pos < 17'(LinkHdrBytes - 1)) begin
            o_result.short_frame = 1'b1;
        end else begin
            if (n_hw >= MinHdrWds && ipb >= {11'b0, hlen})
                o_result.ip_status = (n_hsum == SumOk) ? StValid : StInvalid;
            if (n_proto == ProtoTcp)
                o_result.transport_kind = KindTcp;
            else if (n_proto == ProtoUdp)
                o_result.transport_kind = KindUdp;
            if (n_proto == ProtoTcp || n_proto == ProtoUdp) begin
                if (n_hw < MinHdrWds || n_dlen < {10'b0, hlen} || tlen < minlen
                    || ipb < {1'b0, n_dlen})
                    o_result.transport_status = StUnknown;
                else if (n_proto == ProtoUdp && n_udpz)
                    o_result.transport_status = StNotChk;
                else
                    o_result.transport_status = (fsum == SumOk) ? StValid : StInvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_pos   <= '0;
            r_hw    <= '0;
            r_dlen  <= '0;
            r_proto <= '0;
            r_hsum  <= '0;
            r_tsum  <= '0;
            r_pend  <= '0;
            r_udpz  <= 1'b1;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_hw    <= n_hw;
            r_dlen  <= n_dlen;
            r_proto <= n_proto;
            r_hsum  <= n_hsum;
            r_tsum  <= n_tsum;
            r_pend  <= n_pend;
            r_udpz  <= n_udpz;
        end
    end

endmodule

/* sv/ipv4_l4_checksum_validate.sv */
// Result path: a frame's last byte passes the input register, steps the parser and is registered in r_out.
// Throughput: one byte per cycle; a non-final byte never waits on the result side,
// a final byte waits only while the previous result is still held.
// Reset: synchronous, active low; clears the input and result valid flags and the
// per-frame parse state, which also returns to reset after each final byte.
module ipv4_l4_checksum_validate (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv4cv_in_if.sink     i_frame,
    ipv4cv_out_if.source  o_result
);
    import ipv4cv_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       step;

    // a final byte needs a free result slot; other bytes just update state
    assign step          = r_in_valid && (!r_in_end || !r_out_valid || o_result.ready);
    assign i_frame.ready = !r_in_valid || step;

    ipv4cv_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_in_byte <= i_frame.frame_byte;
            r_in_end  <= i_frame.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_end) begin
            r_out <= res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.ip_status        = r_out.ip_status;
    assign o_result.transport_kind   = r_out.transport_kind;
    assign o_result.transport_status = r_out.transport_status;
    assign o_result.short_frame      = r_out.short_frame;

endmodule

/* sv/ipv4cv_checker.sv */
// Port-level assertions for the checksum checker, bound to the top level.
module ipv4cv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_ip_status,
    input logic [1:0] i_transport_kind,
    input logic [1:0] i_transport_status,
    input logic       i_short_frame
);
    import ipv4cv_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ip_status)
            && $stable(i_transport_status) && $stable(i_short_frame))
        else $error("result beat changed while stalled");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_short_frame |-> i_ip_status == StUnknown
            && i_transport_kind == KindOther && i_transport_status == StNotChk)
        else $error("short frame with inconsistent status");

    a_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_transport_kind == KindOther |-> i_transport_status == StNotChk)
        else $error("non-TCP/UDP frame reported a transport check");

    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind ipv4_l4_checksum_validate ipv4cv_checker u_ipv4cv_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_ip_status        (o_result.ip_status),
    .i_transport_kind   (o_result.transport_kind),
    .i_transport_status (o_result.transport_status),
    .i_short_frame      (o_result.short_frame)
);

/* bench/tb.sv */
// Testbench for ipv4_l4_checksum_validate: directed and random framed byte streams against a parse/sum predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4cv_pkg::*;

    localparam logic [7:0] ProtoIcmp = 8'd1;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_frame_beat;

    logic i_clk;
    logic i_rst_n;

    ipv4cv_in_if  in_if ();
    ipv4cv_out_if out_if ();

    ipv4_l4_checksum_validate DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (in_if),
        .o_result (out_if)
    );

    t_frame_beat beat_q[$];
    t_result     verdict_q[$];
    int          fail_count   = 0;
    int          result_count = 0;
    int          beats_queued = 0;

    // sender burst/gap and receiver stall state
    int gap_left    = 0;
    int burst_left  = 0;
    int sink_mode   = 0;
    int mode_left   = 0;
    int stall_left  = 0;

    // predictor state
    logic [16:0] pp_pos;
    logic [3:0]  pp_words;
    logic [15:0] pp_total;
    logic [7:0]  pp_proto;
    logic [15:0] pp_hsum;
    logic [15:0] pp_lsum;
    logic [7:0]  pp_hold;
    logic        pp_udpz;

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.frame_byte = 8'h00;
        in_if.frame_end  = 1'b0;
        out_if.ready     = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] end_carry_add(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] s;
        s = 32'(a) + 32'(b);
        return 16'(s) + 16'(s >> 16);
    endfunction

    function automatic logic [15:0] fold16(input logic [31:0] acc);
        logic [31:0] s;
        s = (acc & 32'hFFFF) + (acc >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        return s[15:0];
    endfunction

    function automatic void parser_clear();
        pp_pos   = '0;
        pp_words = '0;
        pp_total = '0;
        pp_proto = '0;
        pp_hsum  = '0;
        pp_lsum  = '0;
        pp_hold  = '0;
        pp_udpz  = 1'b1;
    endfunction

    function automatic void absorb_ip_byte(input int unsigned rel, input logic [7:0] b);
        int unsigned hlen;
        int unsigned t;
        if (rel == 0) pp_words = b[3:0];
        if (rel == 2) pp_total[15:8] = b;
        if (rel == 3) pp_total[7:0] = b;
        if (rel == 9) pp_proto = b;
        hlen = int'(pp_words) * 4;
        if (rel < hlen) begin
            if ((rel & 1) == 0) begin
                pp_hold = b;
            end else begin
                pp_hsum = end_carry_add(pp_hsum, {pp_hold, b});
                // address words also seed the pseudo-header
                if (rel >= 12 && rel <= 19) pp_lsum = end_carry_add(pp_lsum, {pp_hold, b});
            end
        end else if (pp_words >= MinHdrWds && rel < pp_total) begin
            t = rel - hlen;
            if (pp_proto == ProtoUdp && (t == 6 || t == 7) && b != 8'h00) pp_udpz = 1'b0;
            if ((rel & 1) == 0) begin
                if (rel + 1 == pp_total) pp_lsum = end_carry_add(pp_lsum, {b, 8'h00});
                else pp_hold = b;
            end else begin
                pp_lsum = end_carry_add(pp_lsum, {pp_hold, b});
            end
        end
    endfunction

    // advance by one accepted beat; returns 1 with the frame verdict on the last byte
    function automatic bit parse_beat(input logic [7:0] b, input logic last,
                                      output t_result r);
        int unsigned pos;
        int unsigned count;
        int unsigned ipb;
        int unsigned hlen;
        int unsigned tlen;
        int unsigned minlen;
        logic [15:0] s;
        pos = pp_pos;
        r   = '0;
        if (pos >= LinkHdrBytes) absorb_ip_byte(pos - LinkHdrBytes, b);
        if (pp_pos != PosMax) pp_pos = pp_pos + 17'd1;
        if (!last) return 1'b0;
        count = pos + 1;
        if (count < LinkHdrBytes) begin
            r.ip_status        = StUnknown;
            r.transport_kind   = KindOther;
            r.transport_status = StNotChk;
            r.short_frame      = 1'b1;
        end else begin
            ipb  = count - LinkHdrBytes;
            hlen = int'(pp_words) * 4;
            if (pp_words < MinHdrWds || ipb < hlen) r.ip_status = StUnknown;
            else r.ip_status = (pp_hsum == SumOk) ? StValid : StInvalid;
            if (pp_proto == ProtoTcp) r.transport_kind = KindTcp;
            else if (pp_proto == ProtoUdp) r.transport_kind = KindUdp;
            else r.transport_kind = KindOther;
            if (r.transport_kind == KindOther) begin
                r.transport_status = StNotChk;
            end else if (pp_words < MinHdrWds || pp_total < hlen) begin
                r.transport_status = StUnknown;
            end else begin
                tlen   = pp_total - hlen;
                minlen = (r.transport_kind == KindTcp) ? TcpMinLen : UdpMinLen;
                if (tlen < minlen || ipb < pp_total) begin
                    r.transport_status = StUnknown;
                end else if (r.transport_kind == KindUdp && pp_udpz) begin
                    r.transport_status = StNotChk;
                end else begin
                    s = end_carry_add(end_carry_add(pp_lsum, {8'h00, pp_proto}), 16'(tlen));
                    r.transport_status = (s == SumOk) ? StValid : StInvalid;
                end
            end
        end
        parser_clear();
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input int got_v, input int want_v);
        fail_count++;
        $display("result %0d: %s got %0d want %0d", result_count, what, got_v, want_v);
    endtask

    // build one frame: link header, IPv4 header, transport bytes, padding; optional cut
    task automatic add_datagram(input logic [7:0] proto, input int ihl, input int tlen,
                                input int len_field, input int pad, input int cut,
                                input bit bad_ip, input bit bad_l4, input bit udp_zero);
        logic [7:0]  pkt[$];
        logic [31:0] acc;
        logic [15:0] tot;
        logic [15:0] sum16;
        int hb, base, l4, i, n, ck;
        hb   = (ihl < 5) ? 20 : ihl * 4;
        tot  = (len_field >= 0) ? 16'(len_field) : 16'(hb + tlen);
        base = LinkHdrBytes;
        l4   = base + hb;
        ck   = -1;
        for (i = 0; i < base + hb + tlen + pad; i++) pkt.push_back(8'($urandom));
        pkt[base]      = {4'h4, 4'(ihl)};
        pkt[base + 2]  = tot[15:8];
        pkt[base + 3]  = tot[7:0];
        pkt[base + 9]  = proto;
        pkt[base + 10] = 8'h00;
        pkt[base + 11] = 8'h00;
        if (proto == ProtoUdp && tlen >= 8) begin
            pkt[l4 + 4] = 8'(tlen >> 8);
            pkt[l4 + 5] = 8'(tlen);
            ck = l4 + 6;
        end else if (proto == ProtoTcp && tlen >= 18) begin
            ck = l4 + 16;
        end
        if (ck >= 0) begin
            pkt[ck]     = 8'h00;
            pkt[ck + 1] = 8'h00;
        end
        acc = 32'(proto) + 32'(tlen);
        for (i = 12; i < 20; i += 2) acc += {pkt[base + i], pkt[base + i + 1]};
        for (i = 0; i < tlen; i += 2)
            acc += {pkt[l4 + i], (i + 1 < tlen) ? pkt[l4 + i + 1] : 8'h00};
        sum16 = ~fold16(acc);
        if (bad_l4) sum16 ^= 16'($urandom_range(1, 16'hFFFF));
        if (proto == ProtoUdp) begin
            if (udp_zero) sum16 = 16'h0000;
            else if (sum16 == 16'h0000) sum16 = 16'hFFFF;
        end
        if (ck >= 0) begin
            pkt[ck]     = sum16[15:8];
            pkt[ck + 1] = sum16[7:0];
        end
        acc = 0;
        for (i = 0; i < hb; i += 2) acc += {pkt[base + i], pkt[base + i + 1]};
        sum16 = ~fold16(acc);
        if (bad_ip) sum16 ^= 16'($urandom_range(1, 16'hFFFF));
        pkt[base + 10] = sum16[15:8];
        pkt[base + 11] = sum16[7:0];
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (i = 0; i < n; i++) beat_q.push_back('{b: pkt[i], last: (i == n - 1)});
        beats_queued += n;
    endtask

    // raw frame: fill < 0 gives random bytes
    task automatic add_raw(input int len, input int fill);
        int i;
        for (i = 0; i < len; i++)
            beat_q.push_back('{b: (fill < 0) ? 8'($urandom) : 8'(fill), last: (i == len - 1)});
        beats_queued += len;
    endtask

    task automatic wait_drained();
        while (beat_q.size() != 0 || in_if.valid || verdict_q.size() != 0) @(negedge i_clk);
    endtask

    // sender: bursts with random gaps
    always @(posedge i_clk) begin : drive_frames
        t_frame_beat nxt;
        logic        offer;
        t_result     r;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (parse_beat(in_if.frame_byte, in_if.frame_end, r)) verdict_q.push_back(r);
            end
            if (!in_if.valid || in_if.ready) begin
                offer = 1'b0;
                nxt   = '0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (beat_q.size() != 0) begin
                    offer = 1'b1;
                    nxt   = beat_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        gap_left   = $urandom_range(0, 4);
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(0, 31);
                    end
                end
                in_if.valid <= offer;
                if (offer) begin
                    in_if.frame_byte <= nxt.b;
                    in_if.frame_end  <= nxt.last;
                end
            end
        end
    end

    // receiver: switches between always ready, coin flip and stall runs
    always @(posedge i_clk) begin : drive_ready
        logic rdy;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (sink_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else begin
                        rdy = 1'b1;
                        stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                    end
                end
            endcase
            out_if.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdict_q.size() == 0) begin
                flag_mismatch("unexpected beat, ip_status", out_if.ip_status, -1);
            end else begin
                want = verdict_q.pop_front();
                if (out_if.ip_status !== want.ip_status)
                    flag_mismatch("ip_status", out_if.ip_status, want.ip_status);
                if (out_if.transport_kind !== want.transport_kind)
                    flag_mismatch("transport_kind", out_if.transport_kind, want.transport_kind);
                if (out_if.transport_status !== want.transport_status)
                    flag_mismatch("transport_status", out_if.transport_status,
                                  want.transport_status);
                if (out_if.short_frame !== want.short_frame)
                    flag_mismatch("short_frame", out_if.short_frame, want.short_frame);
            end
            result_count++;
        end
    end

    initial begin : stimulus
        int frames_made;
        int pick, sub, ihl, tlen, pad, cut, len_field, full;
        logic [7:0] proto;
        parser_clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        add_raw(1, -1);                                          // single byte
        add_raw(LinkHdrBytes - 1, 8'hFF);                        // longest short frame
        add_raw(LinkHdrBytes, 8'h00);                            // link header only
        add_datagram(ProtoTcp, 5, 20, -1, 0, 0, 0, 0, 0);        // minimal good TCP
        add_datagram(ProtoUdp, 5, 9, -1, 0, 0, 0, 0, 0);         // odd UDP length
        add_datagram(ProtoUdp, 5, 12, -1, 0, 0, 0, 0, 1);        // zero UDP checksum
        add_datagram(ProtoUdp, 5, 16, -1, 0, 0, 0, 1, 0);        // bad UDP checksum
        add_datagram(ProtoTcp, 5, 24, -1, 0, 0, 1, 0, 0);        // bad IP checksum
        add_datagram(ProtoTcp, 4, 20, -1, 0, 0, 0, 0, 0);        // IHL below minimum
        add_datagram(ProtoUdp, 6, 8, -1, 0, LinkHdrBytes + 16, 0, 0, 0); // header cut
        add_datagram(ProtoUdp, 5, 8, 12, 0, 0, 0, 0, 0);         // total below header
        add_datagram(ProtoTcp, 5, 19, -1, 0, 0, 0, 0, 0);        // TCP too short
        add_datagram(ProtoUdp, 5, 7, -1, 0, 0, 0, 0, 0);         // UDP too short
        add_datagram(ProtoTcp, 5, 30, -1, 0, LinkHdrBytes + 35, 0, 0, 0); // datagram cut
        add_datagram(ProtoUdp, 5, 8, -1, 0, LinkHdrBytes + 6, 0, 0, 0);   // no protocol yet
        add_datagram(ProtoIcmp, 5, 8, -1, 0, 0, 0, 0, 0);        // other protocol
        add_datagram(ProtoUdp, 5, 10, -1, 6, 0, 0, 0, 0);        // link padding
        add_datagram(ProtoTcp, 15, 21, -1, 0, 0, 0, 0, 0);       // max options
        add_raw(60, 8'hFF);
        add_raw(60, 8'h00);
        wait_drained();

        frames_made  = 0;
        while (beats_queued < 1400 || frames_made < 40) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       proto = ProtoTcp;
                1, 2:    proto = ProtoUdp;
                default: proto = 8'($urandom);
            endcase
            ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : 5;
            if (proto == ProtoTcp) tlen = $urandom_range(20, 40);
            else if (proto == ProtoUdp) tlen = $urandom_range(8, 30);
            else tlen = $urandom_range(0, 24);
            pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            cut = 0;
            len_field = -1;
            if (pick < 70) begin
                add_datagram(proto, ihl, tlen, -1, pad, 0, $urandom_range(0, 7) == 0,
                             $urandom_range(0, 5) == 0,
                             proto == ProtoUdp && $urandom_range(0, 5) == 0);
            end else if (pick < 90) begin
                sub = $urandom_range(0, 3);
                if (sub == 1) ihl = $urandom_range(0, 15);
                if (sub == 3) tlen = (proto == ProtoTcp) ? $urandom_range(0, 19)
                                                         : $urandom_range(0, 7);
                full = LinkHdrBytes + ((ihl < 5) ? 20 : ihl * 4) + tlen + pad;
                if (sub == 0) cut = $urandom_range(1, full);
                if (sub == 2) len_field = ($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 16'hFFFF)
                                          : $urandom_range(0, 80);
                add_datagram(proto, ihl, tlen, len_field, pad, cut,
                             $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 3) == 0);
            end else begin
                add_raw($urandom_range(1, 60), -1);
            end
            frames_made++;
            if (frames_made == 20) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ipv4_l4_checksum_validate: match");
        end else begin
            $display("ipv4_l4_checksum_validate: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("ipv4_l4_checksum_validate: mismatch");
        $finish;
    end

endmodule
